// ----- hw/rtl/igsdp_pkg.sv -----
// ----------------------------------------------------------------------------
// igsdp_pkg: shared constants and types
// Request, status and configuration codes, grid geometry, cell range and ALU types.
// ----------------------------------------------------------------------------
package igsdp_pkg;
	localparam int GRID_MAX  = 32;
	localparam int CELL_BITS = 24;
	localparam int CELLS     = GRID_MAX * GRID_MAX;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int IDX_W     = $clog2(GRID_MAX);

	localparam logic [2:0] REQ_STAMP = 3'd0;
	localparam logic [2:0] REQ_DECAY = 3'd1;
	localparam logic [2:0] REQ_READ  = 3'd2;
	localparam logic [2:0] REQ_PEAK  = 3'd3;
	localparam logic [2:0] REQ_WRITE = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OOB   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
	localparam logic [1:0] CFG_FACTOR    = 2'd1;
	localparam logic [1:0] CFG_FLOOR     = 2'd2;

	localparam logic signed [CELL_BITS-1:0] CELL_HI = {1'b0, {(CELL_BITS-1){1'b1}}};
	localparam logic signed [CELL_BITS-1:0] CELL_LO = {1'b1, {(CELL_BITS-1){1'b0}}};

	// operation for the shared cell unit
	typedef enum logic [1:0] {
		OP_ADD,
		OP_LOAD,
		OP_DECAY
	} alu_op_t;

	typedef struct packed {
		alu_op_t                     op;
		logic signed [CELL_BITS-1:0] cell_val;
		logic signed [31:0]          product;
		logic signed [CELL_BITS-1:0] sample;
		logic [16:0]                 factor;
		logic [22:0]                 floor_val;
	} alu_in_t;

	typedef struct packed {
		logic signed [CELL_BITS-1:0] result;
		logic                        sat;
		logic [CELL_BITS-1:0]        mag;
	} alu_out_t;
endpackage

// ----- hw/rtl/influence_grid_stamp_decay_peak.sv -----
// ----------------------------------------------------------------------------
// influence_grid_stamp_decay_peak: influence map grid engine
// Square grid of Q12.12 cells with stamp, decay, read, write and peak search.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue a request; exactly one result comes
// back on done for one cycle and must be taken then, the receiver cannot
// stall it. After reset a clearing pass zeroes the 1024-entry cell memory,
// one entry a cycle, with busy high; configuration writes are accepted
// throughout. Read, write and stamp step through address, memory read,
// modify/write and result states before done; a request that misses the
// grid, an illegal request and find-peak on an empty grid go straight from
// address to result. Decay and find-peak walk the grid_size*grid_size cells
// through the single memory read port, one cell a cycle. Change
// configuration only while busy is low.
module influence_grid_stamp_decay_peak (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data,
	input  logic [2:0]  req_type,
	input  logic signed [7:0] pos_x,
	input  logic signed [7:0] pos_y,
	input  logic [5:0]  template_size,
	input  logic [4:0]  off_x,
	input  logic [4:0]  off_y,
	input  logic signed [23:0] sample_value,
	input  logic signed [7:0]  magnitude,
	output logic signed [23:0] cell_value,
	output logic [4:0]  peak_x,
	output logic [4:0]  peak_y,
	output logic [1:0]  status
);
	import igsdp_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]  state_q;
	logic [5:0]  grid_size_q;
	logic [16:0] factor_q;
	logic [22:0] floor_q;

	logic [CELL_BITS-1:0] mem [CELLS];
	logic [CELL_BITS-1:0] rdata_q;
	logic [ADDR_W:0]      addr_q;     // cell counter / address, one extra bit
	logic [ADDR_W-1:0]    wr_addr_q;  // address of cell being read, lagging
	logic                 rd_valid_q;
	logic [IDX_W-1:0]     row_q, col_q, wrow_q, wcol_q;

	logic [2:0]  req_q;
	logic signed [CELL_BITS-1:0] sample_q;
	logic signed [31:0]          prod_q;
	logic [ADDR_W:0]             n_cells_q;

	logic [CELL_BITS-1:0] best_mag_q;
	logic signed [CELL_BITS-1:0] best_val_q;
	logic [IDX_W-1:0]     best_row_q, best_col_q;
	logic                 first_q;

	logic signed [CELL_BITS-1:0] res_val_q;
	logic [1:0]  res_st_q;
	logic        done_q;

	// effective grid side, clamped to GRID_MAX
	logic [6:0] gs;
	assign gs = (grid_size_q > 6'(GRID_MAX)) ? 7'(GRID_MAX) : {1'b0, grid_size_q};

	// target cell for the single-cell requests
	logic signed [9:0] tr, tc;
	logic              inb;
	always_comb begin
		tr = 10'(pos_x);
		tc = 10'(pos_y);
		if (req_type == REQ_STAMP) begin
			tr = 10'(pos_x) - 10'(template_size >> 1) + 10'(off_x);
			tc = 10'(pos_y) - 10'(template_size >> 1) + 10'(off_y);
		end
		inb = (tr >= 0) && (tr < 10'(gs)) && (tc >= 0) && (tc < 10'(gs));
		if (req_type == REQ_STAMP && ({1'b0, off_x} >= template_size ||
		    {1'b0, off_y} >= template_size))
			inb = 1'b0;
	end

	alu_in_t  alu_in;
	alu_out_t alu_out;
	always_comb begin
		alu_in.cell_val  = rdata_q;
		alu_in.product   = prod_q;
		alu_in.sample    = sample_q;
		alu_in.factor    = (factor_q > 17'd65536) ? 17'd65536 : factor_q;
		alu_in.floor_val = floor_q;
		case (req_q)
			REQ_STAMP: alu_in.op = OP_ADD;
			REQ_WRITE: alu_in.op = OP_LOAD;
			default:   alu_in.op = OP_DECAY;
		endcase
	end

	igsdp_cell_alu u_alu (.a(alu_in), .y(alu_out));

	// single-port-read cell memory
	logic                 we;
	logic [ADDR_W-1:0]    waddr;
	logic [CELL_BITS-1:0] wdata;
	logic                 walking_rd;
	always_comb begin
		we    = 1'b0;
		waddr = wr_addr_q;
		wdata = alu_out.result;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = addr_q[ADDR_W-1:0];
			wdata = '0;
		end else if (state_q == S_MOD && req_q != REQ_READ) begin
			we = 1'b1;
		end else if (state_q == S_WALK && rd_valid_q && req_q == REQ_DECAY) begin
			we = 1'b1;
		end
	end
	assign walking_rd = (state_q == S_WALK) && (addr_q < n_cells_q);

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[addr_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= 6'd32;
			factor_q    <= 17'd65536;
			floor_q     <= 23'd41;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_SIZE: grid_size_q <= cfg_data[5:0];
				CFG_FACTOR:    factor_q    <= cfg_data[16:0];
				CFG_FLOOR:     floor_q     <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			addr_q     <= '0;
			done_q     <= 1'b0;
			rd_valid_q <= 1'b0;
			req_q      <= REQ_READ;
			sample_q   <= '0;
			prod_q     <= '0;
			n_cells_q  <= '0;
			wr_addr_q  <= '0;
			row_q <= '0; col_q <= '0;
			wrow_q <= '0; wcol_q <= '0;
			first_q    <= 1'b0;
			best_mag_q <= '0; best_val_q <= '0;
			best_row_q <= '0; best_col_q <= '0;
			res_val_q  <= '0;
			res_st_q   <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == (ADDR_W+1)'(CELLS-1)) begin
						state_q <= S_IDLE;
						addr_q  <= '0;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q    <= req_type;
						sample_q <= sample_value;
						prod_q   <= 32'(sample_value) * 32'(magnitude);
						res_val_q <= '0;
						res_st_q  <= ST_OK;
						n_cells_q <= (ADDR_W+1)'(gs) * (ADDR_W+1)'(gs);
						addr_q    <= '0;
						row_q <= '0; col_q <= '0;
						first_q <= 1'b1;
						rd_valid_q <= 1'b0;
						best_mag_q <= '0; best_val_q <= '0;
						best_row_q <= '0; best_col_q <= '0;
						case (req_type)
							REQ_STAMP, REQ_READ, REQ_WRITE: begin
								if (inb) begin
									addr_q    <= (ADDR_W+1)'(tr * 10'(gs) + tc);
									wr_addr_q <= ADDR_W'(tr * 10'(gs) + tc);
									state_q   <= S_RD;
								end else begin
									res_st_q <= ST_OOB;
									state_q  <= S_DONE;
								end
							end
							REQ_DECAY: state_q <= S_WALK;
							REQ_PEAK: begin
								if (gs == 7'd0) begin
									res_st_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_WALK;
								end
							end
							default: begin
								res_st_q <= ST_OOB;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_RD: state_q <= S_MOD;
				S_MOD: begin
					res_val_q <= (req_q == REQ_READ) ? rdata_q : alu_out.result;
					res_st_q  <= (req_q != REQ_READ && alu_out.sat) ? ST_SAT : ST_OK;
					state_q <= S_DONE;
				end
				S_WALK: begin
					// register the read address so the write goes to the cell just read
					rd_valid_q <= walking_rd;
					wr_addr_q  <= addr_q[ADDR_W-1:0];
					wrow_q <= row_q;
					wcol_q <= col_q;
					if (walking_rd) begin
						addr_q <= addr_q + 1'b1;
						if (7'(col_q) == gs - 7'd1) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
					if (rd_valid_q && req_q == REQ_PEAK) begin
						if (first_q || best_mag_q < alu_out.mag) begin
							best_mag_q <= alu_out.mag;
							best_val_q <= rdata_q;
							best_row_q <= wrow_q;
							best_col_q <= wcol_q;
						end
						first_q <= 1'b0;
					end
					if (!walking_rd && !rd_valid_q) begin
						state_q <= S_DONE;
						if (req_q == REQ_PEAK)
							res_val_q <= best_val_q;
					end
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign cell_value = res_val_q;
	assign status     = res_st_q;
	assign peak_x     = (req_q == REQ_PEAK && res_st_q == ST_OK) ? best_row_q : '0;
	assign peak_y     = (req_q == REQ_PEAK && res_st_q == ST_OK) ? best_col_q : '0;

	// a result appears only right after the result state
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_DONE) else $error("stray done");
	// no request is taken during the clearing pass
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> busy) else $error("idle during clear");
	// an empty-grid status only answers find-peak
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EMPTY |-> req_q == REQ_PEAK) else $error("bad empty status");
endmodule

// ----- hw/rtl/igsdp_cell_alu.sv -----
// ----------------------------------------------------------------------------
// igsdp_cell_alu: shared cell arithmetic
// Saturating add, plain load and floored decay scaling of one cell.
// ----------------------------------------------------------------------------
module igsdp_cell_alu (
	input  igsdp_pkg::alu_in_t  a,
	output igsdp_pkg::alu_out_t y
);
	import igsdp_pkg::*;

	logic signed [CELL_BITS+8:0] sum;
	logic [CELL_BITS-1:0]        mag;
	logic [CELL_BITS+17:0]       scaled;
	logic [CELL_BITS-1:0]        rnd;

	always_comb begin
		mag    = a.cell_val[CELL_BITS-1] ? CELL_BITS'(-a.cell_val) : CELL_BITS'(a.cell_val);
		scaled = (CELL_BITS+18)'(mag) * (CELL_BITS+18)'(a.factor) + (CELL_BITS+18)'(32768);
		rnd    = scaled[CELL_BITS+15:16];
		sum    = '0;
		y.mag  = mag;
		y.sat  = 1'b0;
		y.result = '0;
		case (a.op)
			OP_ADD: begin
				sum = (CELL_BITS+9)'(a.cell_val) + (CELL_BITS+9)'(a.product);
				if (sum > (CELL_BITS+9)'(CELL_HI)) begin
					y.result = CELL_HI;
					y.sat    = 1'b1;
				end else if (sum < (CELL_BITS+9)'(CELL_LO)) begin
					y.result = CELL_LO;
					y.sat    = 1'b1;
				end else begin
					y.result = CELL_BITS'(sum);
				end
			end
			OP_LOAD: y.result = a.sample;
			OP_DECAY: begin
				if ({1'b0, mag} > (CELL_BITS+1)'(a.floor_val))
					y.result = a.cell_val[CELL_BITS-1] ? CELL_BITS'(-rnd) : CELL_BITS'(rnd);
				else
					y.result = '0;
			end
			default: y.result = '0;
		endcase
	end
endmodule
